>>> sv/bqr_pkg.sv
`timescale 1ns / 1ps
// bqr_pkg: shared types and codes of the bounded queue with removal
// depends on nothing; used by the interfaces, bqr_engine and the top level

package bqr_pkg;

  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;

  // operation codes, code 3 is ignored
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

>>> sv/bqr_if.sv
`timescale 1ns / 1ps
// bqr_in_if / bqr_out_if: valid-ready channels of the queue block
// depends on bqr_pkg for field widths

interface bqr_in_if;
  logic                         valid;
  logic                         ready;
  logic [bqr_pkg::OP_W-1:0]     operation;
  logic [bqr_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface bqr_out_if;
  logic                         valid;
  logic                         ready;
  logic [bqr_pkg::ST_W-1:0]     status;
  logic [bqr_pkg::DATA_W-1:0]   result_value;
  logic [bqr_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output result_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input result_value, input entry_count,
                  output ready);
endinterface

>>> sv/bqr_engine.sv
`timescale 1ns / 1ps
// bqr_engine: circular entry memory plus the sequencer for enqueue, dequeue and remove
// depends on bqr_pkg

module bqr_engine #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bqr_pkg::CAP_W-1:0]   capacity,
  input  logic                        req_valid,
  input  bqr_pkg::req_t               req,
  input  logic                        res_take,
  output bqr_pkg::eng_stat_t          stat,
  output bqr_pkg::rsp_t               rsp
);

  localparam int AW  = $clog2(DEPTH);
  localparam int SW  = ((AW > bqr_pkg::CNT_W) ? AW : bqr_pkg::CNT_W) + 1;
  localparam int SVW = (VALUE_WIDTH < bqr_pkg::DATA_W) ? VALUE_WIDTH : bqr_pkg::DATA_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  logic [SVW-1:0] mem [DEPTH];
  logic [SVW-1:0] rdata_r;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [bqr_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bqr_pkg::CNT_W-1:0]     iss_r, iss_nxt;
  logic                          pend_r, pend_nxt;
  logic [bqr_pkg::CNT_W-1:0]     pend_off_r, pend_off_nxt;
  logic                          found_r, found_nxt;
  logic [bqr_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [SVW-1:0]                val_r, val_nxt;
  bqr_pkg::rsp_t                 rsp_r, rsp_nxt;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [SVW-1:0]                mem_wdata;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          full;
  logic                          last;

  // physical slot of a logical offset from the front
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                            input logic [bqr_pkg::CNT_W-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[AW-1:0];
  endfunction

  assign full = (cnt_r >= capacity) || (SW'(cnt_r) >= DEPTH_S);
  assign last = (pend_off_r == (cnt_r - 5'd1));

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    iss_nxt      = iss_r;
    pend_nxt     = 1'b0;
    pend_off_nxt = pend_off_r;
    found_nxt    = found_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    rsp_nxt      = rsp_r;
    mem_we       = 1'b0;
    mem_waddr    = head_r;
    mem_wdata    = val_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt  = req.op;
          val_nxt = req.value[SVW-1:0];
          case (req.op) inside
            bqr_pkg::OP_ENQUEUE: begin
              if (full) begin
                rsp_nxt = '{status: bqr_pkg::ST_FULL, value: '0, count: cnt_r};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_add(head_r, cnt_r);
                mem_wdata = req.value[SVW-1:0];
                cnt_nxt   = cnt_r + 5'd1;
                rsp_nxt   = '{status: bqr_pkg::ST_OK,
                              value: bqr_pkg::DATA_W'(req.value[SVW-1:0]),
                              count: cnt_r + 5'd1};
              end
              state_nxt = S_DONE;
            end
            bqr_pkg::OP_DEQUEUE, bqr_pkg::OP_REMOVE: begin
              if (cnt_r == '0) begin
                rsp_nxt   = '{status: bqr_pkg::ST_EMPTY, value: '0, count: cnt_r};
                state_nxt = S_DONE;
              end else begin
                // front entry read goes out in the accept cycle
                rd_en        = 1'b1;
                rd_addr      = head_r;
                pend_nxt     = 1'b1;
                pend_off_nxt = '0;
                iss_nxt      = 5'd1;
                found_nxt    = 1'b0;
                state_nxt    = S_WORK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WORK: begin
        // remove streams one read per cycle through the live entries
        if ((op_r == bqr_pkg::OP_REMOVE) && (iss_r < cnt_r)) begin
          rd_en        = 1'b1;
          rd_addr      = wrap_add(head_r, iss_r);
          pend_nxt     = 1'b1;
          pend_off_nxt = iss_r;
          iss_nxt      = iss_r + 5'd1;
        end
        if (pend_r) begin
          if (op_r == bqr_pkg::OP_DEQUEUE) begin
            head_nxt  = wrap_add(head_r, 5'd1);
            cnt_nxt   = cnt_r - 5'd1;
            rsp_nxt   = '{status: bqr_pkg::ST_OK, value: bqr_pkg::DATA_W'(rdata_r),
                          count: cnt_r - 5'd1};
            state_nxt = S_DONE;
          end else if (found_r || (rdata_r == val_r)) begin
            if (found_r) begin
              // close the gap: entry moves one slot toward the front
              mem_we    = 1'b1;
              mem_waddr = wrap_add(head_r, pend_off_r - 5'd1);
              mem_wdata = rdata_r;
            end
            found_nxt = 1'b1;
            if (last) begin
              cnt_nxt   = cnt_r - 5'd1;
              rsp_nxt   = '{status: bqr_pkg::ST_OK, value: bqr_pkg::DATA_W'(val_r),
                            count: cnt_r - 5'd1};
              state_nxt = S_DONE;
            end
          end else if (last) begin
            rsp_nxt   = '{status: bqr_pkg::ST_NOT_FOUND, value: '0, count: cnt_r};
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    pend_off_r <= pend_off_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    rsp_r      <= rsp_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign rsp       = rsp_r;

endmodule

>>> sv/bounded_queue_with_removal_top.sv
`timescale 1ns / 1ps
// order, accept to result valid: enqueue, full and empty go straight to the done state; dequeue
//   reads the front entry first; remove reads through the held entries, one memory read per cycle
// intake: one word at a time; the next word is taken once the sequencer is idle,
//   and the result register frees the input side
// reset: synchronous active-low rst_n empties the queue and sets capacity to 16;
//   entry memory is not cleared, no clearing pass

module bounded_queue_with_removal_top #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bqr_in_if.sink                        in_ch,
  bqr_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bqr_pkg::ADDR_W-1:0]    paddr,
  input  logic [bqr_pkg::PDATA_W-1:0]   pwdata,
  output logic [bqr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // configuration register, one word at byte address 0
  logic [bqr_pkg::CAP_W-1:0] capacity_r, capacity_nxt;
  logic                      cfg_wr;

  // result register between the sequencer and the output channel
  logic                      out_valid_r, out_valid_nxt;
  bqr_pkg::rsp_t             out_data_r;

  // sequencer handshake
  logic                      req_valid;
  bqr_pkg::req_t             req;
  logic                      res_take;
  bqr_pkg::eng_stat_t        stat;
  bqr_pkg::rsp_t             rsp;

  // apb: write on the access phase, pready tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_wr && (paddr[2] == bqr_pkg::REG_CAPACITY)) begin
      capacity_nxt = pwdata[bqr_pkg::CAP_W-1:0];
    end
  end

  // reads of unmapped words return zero
  always_comb begin
    if (paddr[2] == bqr_pkg::REG_CAPACITY) begin
      prdata = bqr_pkg::PDATA_W'(capacity_r);
    end else begin
      prdata = '0;
    end
  end

  // input side: a word enters only while the sequencer is idle,
  // operation code 3 is taken and dropped by the sequencer
  assign in_ch.ready = stat.idle;
  assign req_valid   = in_ch.valid && in_ch.ready;
  assign req.op      = in_ch.operation;
  assign req.value   = in_ch.item_value;

  // move the finished result when the output register is empty or draining
  assign res_take = stat.done && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (res_take)     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= bqr_pkg::CAPACITY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      capacity_r  <= capacity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data_r <= rsp;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_data_r.status;
  assign out_ch.result_value = out_data_r.value;
  assign out_ch.entry_count  = out_data_r.count;

  // memory and sequencer: circular buffer, remove scans and compacts in place
  bqr_engine #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .req_valid (req_valid),
    .req       (req),
    .res_take  (res_take),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

>>> tb/bqr_result_checker.sv
`timescale 1ns / 1ps
// bqr_result_checker: watches the queue block's channels and config port, predicts each result
// depends on bqr_pkg and the channel interfaces in bqr_if.sv

module bqr_result_checker
  import bqr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  bqr_in_if                  in_mon,
  bqr_out_if                 out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 results_due,
  output int                 ok_seen,
  output int                 full_seen,
  output int                 empty_seen,
  output int                 missing_seen
);

  logic [DATA_W-1:0] held_values [$];
  logic [CAP_W-1:0]  capacity_copy;
  rsp_t              due_results [$];

  // applies one operation to the shadow queue and returns its result word
  task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                                output rsp_t r);
    int lim;
    int hit;
    lim = (capacity_copy > DEPTH) ? DEPTH : int'(capacity_copy);
    hit = -1;
    r.status = ST_OK;
    r.value  = '0;
    case (op)
      OP_ENQUEUE: begin
        if (held_values.size() >= lim) begin
          r.status = ST_FULL;
        end else begin
          held_values.push_back(v);
          r.value = v;
        end
      end
      OP_DEQUEUE: begin
        if (held_values.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = held_values.pop_front();
        end
      end
      default: begin
        if (held_values.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          foreach (held_values[i]) if (hit < 0 && held_values[i] == v) hit = i;
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            held_values.delete(hit);
            r.value = v;
          end
        end
      end
    endcase
    r.count = CNT_W'(held_values.size());
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t fresh;
    if (!rst_n) begin
      held_values.delete();
      due_results.delete();
      capacity_copy = CAPACITY_RESET;
      fail_count    = 0;
      ok_seen       = 0;
      full_seen     = 0;
      empty_seen    = 0;
      missing_seen  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_CAPACITY) begin
        capacity_copy = pwdata[CAP_W-1:0];
      end
      // result side first: a result never belongs to a word taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        case (out_mon.status)
          ST_OK:    ok_seen++;
          ST_FULL:  full_seen++;
          ST_EMPTY: empty_seen++;
          default:  missing_seen++;
        endcase
        if (due_results.size() == 0) begin
          $error("unexpected result word: status %0d value %h count %0d",
                 out_mon.status, out_mon.result_value, out_mon.entry_count);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            fail_count++;
          end
          if (out_mon.result_value !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, out_mon.result_value);
            fail_count++;
          end
          if (out_mon.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_mon.entry_count);
            fail_count++;
          end
        end
      end
      // code 3 is dropped by the block and gives no result
      if (in_mon.valid && in_mon.ready &&
          (in_mon.operation inside {OP_ENQUEUE, OP_DEQUEUE, OP_REMOVE})) begin
        apply_queue_op(in_mon.operation, in_mon.item_value, fresh);
        due_results.push_back(fresh);
      end
    end
    results_due = due_results.size();
  end

endmodule

>>> tb/tb_bounded_queue_with_removal_top.sv
`timescale 1ns / 1ps
// tb_bounded_queue_with_removal_top: stimulus, config writes and verdict for the queue block
// depends on bqr_pkg, bqr_if.sv, bounded_queue_with_removal_top and bqr_result_checker

module tb_bounded_queue_with_removal_top;
  import bqr_pkg::*;

  // code 3 has no meaning, the block must drop the word without a result
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int DRAIN_CYCLES = 40;   // covers the longest remove, 16 entries max
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 120;

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bqr_in_if  in_ch ();
  bqr_out_if out_ch ();

  // calm: no idling on either side; start_hold: receiver goes quiet once
  logic calm       = 1'b0;
  logic start_hold = 1'b0;
  logic hold_done  = 1'b0;

  int fail_count;
  int results_due;
  int ok_seen;
  int full_seen;
  int empty_seen;
  int missing_seen;
  int words_sent = 0;
  int cap_writes = 0;

  logic [DATA_W-1:0] value_pool [6];
  logic [CAP_W-1:0]  phase_caps [PHASES];

  always #1 clk = ~clk;

  bounded_queue_with_removal_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bqr_result_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .ok_seen      (ok_seen),
    .full_seen    (full_seen),
    .empty_seen   (empty_seen),
    .missing_seen (missing_seen)
  );

  // result side: random back-pressure, one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (start_hold && !hold_done) begin
      out_ch.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_done <= 1'b1;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 22);
    end
  end

  // offers one word, at times with a random gap ahead of it, and returns at the accepting edge
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.item_value <= v;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
  endtask

  // capacity write over the config port, only once the block has gone quiet
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_ch.valid <= 1'b0;
    // step past the accepting edge first so the checker has counted the last accepted word
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    // a dropped code-3 word never leaves the idle sequencer, so nothing of it is in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= ($urandom() & ~32'h1f) | PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_writes++;
  endtask

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] v;
    logic              filling;
    int                roll;
    int                guard;

    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_ENQUEUE;
    in_ch.item_value <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_n            <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, ignored code, extreme values, duplicates, removal from the middle
    send_word(OP_DEQUEUE, 32'h0);
    send_word(OP_REMOVE,  32'hffff_ffff);
    send_word(OP_IGNORED, 32'hdead_beef);
    send_word(OP_ENQUEUE, 32'h0000_0000);
    send_word(OP_ENQUEUE, 32'hffff_ffff);
    send_word(OP_ENQUEUE, 32'h5a5a_5a5a);
    send_word(OP_ENQUEUE, 32'ha5a5_a5a5);
    send_word(OP_ENQUEUE, 32'h5a5a_5a5a);
    send_word(OP_REMOVE,  32'h5a5a_5a5a);   // first of two equal entries goes
    send_word(OP_REMOVE,  32'h1234_5678);   // no match, queue untouched
    send_word(OP_DEQUEUE, 32'hffff_ffff);   // value ignored on dequeue
    send_word(OP_REMOVE,  32'hffff_ffff);
    send_word(OP_IGNORED, 32'h0);
    // capacity dropped below the current count: enqueue full, the rest still works
    set_capacity(5'd1);
    send_word(OP_ENQUEUE, 32'h0bad_f00d);
    send_word(OP_DEQUEUE, 32'h0);
    send_word(OP_ENQUEUE, 32'h1111_1111);
    send_word(OP_DEQUEUE, 32'h0);
    send_word(OP_ENQUEUE, 32'h7777_7777);
    // capacity zero: every enqueue is full
    set_capacity(5'd0);
    send_word(OP_ENQUEUE, 32'hffff_ffff);
    send_word(OP_DEQUEUE, 32'h0);
    send_word(OP_DEQUEUE, 32'h0);
    send_word(OP_REMOVE,  32'h0);

    // random phases, capacity extremes among them (31 clips to the depth)
    phase_caps = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd15, 5'd0, 5'd8};
    phase_caps[6]  = CAP_W'($urandom_range(0, 31));
    phase_caps[10] = CAP_W'($urandom_range(0, 31));
    filling = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(phase_caps[ph]);
      foreach (value_pool[i]) value_pool[i] = $urandom();
      if (ph == 7) calm <= 1'b1;
      if (ph == 8) calm <= 1'b0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // alternate fill and drain so the count sweeps the whole range
        if (k % 30 == 0) filling = ~filling;
        // receiver goes quiet while words keep coming, the block backs up
        if (ph == 1 && k == 20) start_hold <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll >= 97) begin
          op = OP_IGNORED;
        end else if (roll < (filling ? 60 : 25)) begin
          op = OP_ENQUEUE;
        end else if (roll < (filling ? 80 : 60)) begin
          op = OP_DEQUEUE;
        end else begin
          op = OP_REMOVE;
        end
        // mostly pool values so removes find matches and duplicates occur
        if ($urandom_range(0, 99) < 72) begin
          v = value_pool[$urandom_range(0, 5)];
        end else begin
          v = $urandom();
        end
        send_word(op, v);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (results_due != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d words over %0d capacity writes, incl. 0, 1, 16 and 31",
             words_sent, cap_writes);
    $display("results seen: %0d ok, %0d full, %0d empty, %0d not found",
             ok_seen, full_seen, empty_seen, missing_seen);
    if (fail_count == 0 && results_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
